[design/rod_pkg.sv]
`timescale 1ns / 1ps

package rod_pkg;

   // Framebuffer geometry.
   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 128;
   localparam int FB_DEPTH    = MAX_COLUMNS * MAX_ROWS;
   localparam int FB_AW       = $clog2(FB_DEPTH);

   // Field and datapath widths.
   localparam int REG_W    = 8;
   localparam int FIELD_W  = 9;
   localparam int COORD_W  = FIELD_W + 1;
   localparam int SPAN_W   = FIELD_W - 1;
   localparam int COLOR_W  = 8;
   localparam int PROD_W   = COORD_W + REG_W;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 8;
   localparam int CSR_IW   = 1;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Configuration register indexes.
   localparam logic [CSR_IW-1:0] CSR_COLUMNS = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_ROWS    = 1'd1;

   // Request command field codes.
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [1:0] {
      KIND_DRAW = 2'd0,
      KIND_READ = 2'd1,
      KIND_NOP  = 2'd2
   } kind_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      kind_type             kind;
      logic [COORD_W-1:0]   x_org;
      logic [COORD_W-1:0]   y_org;
      logic [COORD_W-1:0]   x_far;
      logic [COORD_W-1:0]   y_far;
      logic                 neg_x;
      logic                 neg_y;
      logic [SPAN_W-1:0]    span_x;
      logic [SPAN_W-1:0]    span_y;
      logic [COLOR_W-1:0]   color;
   } cmd_type;

   // Image size in use, already limited to the framebuffer maximum.
   typedef struct packed {
      logic [REG_W-1:0] cols;
      logic [REG_W-1:0] rows;
   } dims_type;

endpackage

[design/rod_front.sv]
`timescale 1ns / 1ps

module rod_front (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [rod_pkg::REQ_W-1:0] req_tdata,
   input  logic                    queue_full,
   input  logic                    clear_active,
   output logic                    push,
   output rod_pkg::cmd_type        item
);

   logic                           command;
   logic [rod_pkg::FIELD_W-1:0]    x_field;
   logic [rod_pkg::FIELD_W-1:0]    y_field;
   logic [rod_pkg::FIELD_W-1:0]    w_field;
   logic [rod_pkg::FIELD_W-1:0]    h_field;
   logic [rod_pkg::COORD_W-1:0]    x_ext;
   logic [rod_pkg::COORD_W-1:0]    y_ext;
   logic [rod_pkg::COORD_W-1:0]    w_ext;
   logic [rod_pkg::COORD_W-1:0]    h_ext;
   logic [rod_pkg::COORD_W-1:0]    w_far;
   logic [rod_pkg::COORD_W-1:0]    h_far;

   assign command = req_tdata[0];
   assign x_field = req_tdata[9:1];
   assign y_field = req_tdata[18:10];
   assign w_field = req_tdata[27:19];
   assign h_field = req_tdata[36:28];

   assign req_tready = !queue_full && !clear_active;
   assign push       = req_tvalid && req_tready;

   assign x_ext = {x_field[rod_pkg::FIELD_W-1], x_field};
   assign y_ext = {y_field[rod_pkg::FIELD_W-1], y_field};
   assign w_ext = {w_field[rod_pkg::FIELD_W-1], w_field};
   assign h_ext = {h_field[rod_pkg::FIELD_W-1], h_field};

   // The far edge lies one step short of origin plus size, toward the origin.
   assign w_far = w_field[rod_pkg::FIELD_W-1] ? w_ext + rod_pkg::COORD_W'(1)
                                              : w_ext - rod_pkg::COORD_W'(1);
   assign h_far = h_field[rod_pkg::FIELD_W-1] ? h_ext + rod_pkg::COORD_W'(1)
                                              : h_ext - rod_pkg::COORD_W'(1);

   always_comb begin
      item.x_org  = x_ext;
      item.y_org  = y_ext;
      item.x_far  = x_ext + w_far;
      item.y_far  = y_ext + h_far;
      item.neg_x  = w_field[rod_pkg::FIELD_W-1];
      item.neg_y  = h_field[rod_pkg::FIELD_W-1];
      // Edge length minus one: |size|-1, which for a negative size is ~size.
      item.span_x = w_field[rod_pkg::FIELD_W-1] ? ~w_field[rod_pkg::SPAN_W-1:0]
                                                : w_field[rod_pkg::SPAN_W-1:0]
                                                  - rod_pkg::SPAN_W'(1);
      item.span_y = h_field[rod_pkg::FIELD_W-1] ? ~h_field[rod_pkg::SPAN_W-1:0]
                                                : h_field[rod_pkg::SPAN_W-1:0]
                                                  - rod_pkg::SPAN_W'(1);
      item.color  = req_tdata[44:37];
      if (command == rod_pkg::CMD_READ) begin
         item.kind = rod_pkg::KIND_READ;
      end else if (w_field == '0 || h_field == '0) begin
         item.kind = rod_pkg::KIND_NOP;
      end else begin
         item.kind = rod_pkg::KIND_DRAW;
      end
   end

endmodule

[design/rod_queue.sv]
`timescale 1ns / 1ps

module rod_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rod_pkg::cmd_type push_item,
   input  logic             pop,
   output rod_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);

   rod_pkg::cmd_type                entry_ff [rod_pkg::QUEUE_DEPTH];
   logic [rod_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [rod_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [rod_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [rod_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [rod_pkg::QCNT_W-1:0]      count_ff;
   logic [rod_pkg::QCNT_W-1:0]      count_in;
   logic                            do_push;
   logic                            do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == rod_pkg::QCNT_W'(rod_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rod_pkg::QPTR_W'(rod_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + rod_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rod_pkg::QPTR_W'(rod_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + rod_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + rod_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - rod_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/rod_back.sv]
`timescale 1ns / 1ps

module rod_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rod_pkg::dims_type         dims,
   input  rod_pkg::cmd_type          head,
   input  logic                      empty,
   output logic                      pop,
   output logic                      clear_active,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [rod_pkg::RSP_W-1:0] rsp_tdata
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_DRAW  = 6'b000100,
      ST_READ  = 6'b001000,
      ST_RDATA = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      EDGE_TOP    = 4'b0001,
      EDGE_BOTTOM = 4'b0010,
      EDGE_LEFT   = 4'b0100,
      EDGE_RIGHT  = 4'b1000
   } edge_type;

   logic [rod_pkg::COLOR_W-1:0]  fb_mem [rod_pkg::FB_DEPTH];

   state_type                    state_ff;
   state_type                    state_in;
   edge_type                     edge_ff;
   edge_type                     edge_in;
   rod_pkg::cmd_type             cmd_ff;
   rod_pkg::cmd_type             cmd_in;
   logic [rod_pkg::SPAN_W-1:0]   idx_ff;
   logic [rod_pkg::SPAN_W-1:0]   idx_in;
   logic [rod_pkg::FB_AW-1:0]    clr_ff;
   logic [rod_pkg::FB_AW-1:0]    clr_in;
   logic [rod_pkg::RSP_W-1:0]    res_ff;
   logic [rod_pkg::RSP_W-1:0]    res_in;
   logic                         rd_ok_ff;
   logic [rod_pkg::COLOR_W-1:0]  rd_data_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [rod_pkg::RSP_W-1:0]    rsp_data_ff;
   logic [rod_pkg::RSP_W-1:0]    rsp_data_in;

   logic [rod_pkg::COORD_W-1:0]  off_x;
   logic [rod_pkg::COORD_W-1:0]  off_y;
   logic [rod_pkg::COORD_W-1:0]  px;
   logic [rod_pkg::COORD_W-1:0]  py;
   logic                         in_range;
   logic [rod_pkg::PROD_W-1:0]   prod;
   logic [rod_pkg::FB_AW-1:0]    pix_addr;
   logic [rod_pkg::SPAN_W-1:0]   edge_last;
   logic                         wr_en;
   logic [rod_pkg::FB_AW-1:0]    wr_addr;
   logic [rod_pkg::COLOR_W-1:0]  wr_data;
   logic                         out_free;

   assign clear_active = (state_ff == ST_CLEAR);
   assign pop          = (state_ff == ST_IDLE) && !empty;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   // Offset of the current pixel along its edge, toward the far side.
   assign off_x = cmd_ff.neg_x ? rod_pkg::COORD_W'(0) - rod_pkg::COORD_W'(idx_ff)
                               : rod_pkg::COORD_W'(idx_ff);
   assign off_y = cmd_ff.neg_y ? rod_pkg::COORD_W'(0) - rod_pkg::COORD_W'(idx_ff)
                               : rod_pkg::COORD_W'(idx_ff);

   always_comb begin
      if (state_ff == ST_READ) begin
         px        = cmd_ff.x_org;
         py        = cmd_ff.y_org;
         edge_last = cmd_ff.span_x;
      end else begin
         unique case (edge_ff)
            EDGE_TOP: begin
               px        = cmd_ff.x_org + off_x;
               py        = cmd_ff.y_org;
               edge_last = cmd_ff.span_x;
            end
            EDGE_BOTTOM: begin
               px        = cmd_ff.x_org + off_x;
               py        = cmd_ff.y_far;
               edge_last = cmd_ff.span_x;
            end
            EDGE_LEFT: begin
               px        = cmd_ff.x_org;
               py        = cmd_ff.y_org + off_y;
               edge_last = cmd_ff.span_y;
            end
            EDGE_RIGHT: begin
               px        = cmd_ff.x_far;
               py        = cmd_ff.y_org + off_y;
               edge_last = cmd_ff.span_y;
            end
            default: begin
               px        = cmd_ff.x_org;
               py        = cmd_ff.y_org;
               edge_last = cmd_ff.span_x;
            end
         endcase
      end
   end

   // Clip each pixel on its own, then form the row-major address.
   assign in_range = !px[rod_pkg::COORD_W-1] && !py[rod_pkg::COORD_W-1]
                     && (px < rod_pkg::COORD_W'(dims.cols))
                     && (py < rod_pkg::COORD_W'(dims.rows));
   assign prod     = rod_pkg::PROD_W'(py) * rod_pkg::PROD_W'(dims.cols)
                     + rod_pkg::PROD_W'(px);
   assign pix_addr = prod[rod_pkg::FB_AW-1:0];

   assign wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_DRAW) && in_range);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : pix_addr;
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : cmd_ff.color;

   always_comb begin
      state_in     = state_ff;
      edge_in      = edge_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + rod_pkg::FB_AW'(1);
            if (clr_ff == rod_pkg::FB_AW'(rod_pkg::FB_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               cmd_in  = head;
               edge_in = EDGE_TOP;
               idx_in  = '0;
               res_in  = '0;
               unique case (head.kind)
                  rod_pkg::KIND_READ: state_in = ST_READ;
                  rod_pkg::KIND_DRAW: state_in = ST_DRAW;
                  default:            state_in = ST_DONE;
               endcase
            end
         end
         ST_DRAW: begin
            if (idx_ff == edge_last) begin
               idx_in = '0;
               unique case (edge_ff)
                  EDGE_TOP:    edge_in = EDGE_BOTTOM;
                  EDGE_BOTTOM: edge_in = EDGE_LEFT;
                  EDGE_LEFT:   edge_in = EDGE_RIGHT;
                  default:     state_in = ST_DONE;
               endcase
            end else begin
               idx_in = idx_ff + rod_pkg::SPAN_W'(1);
            end
         end
         ST_READ: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            res_in   = rd_ok_ff ? rd_data_ff : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         edge_ff      <= EDGE_TOP;
         idx_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_ff      <= edge_in;
         idx_ff       <= idx_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rd_ok_ff    <= in_range;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fb_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= fb_mem[pix_addr];
   end

endmodule

[design/rectangle_outline_draw.sv]
`timescale 1ns / 1ps

// Rectangle outline rasterizer over an 8-bit grayscale framebuffer of 128 x 128 pixels,
// stored row-major with the row stride set by the column register. After reset the
// framebuffer is cleared one pixel per cycle, and no request is taken until that pass
// ends. Requests go into a two-entry command queue; the back end writes the outline one
// pixel per cycle through the framebuffer's single write port, and each draw or read
// returns one response transaction. Responses wait in an output register, so the queue
// keeps accepting, until it is full, while a response is held.
module rectangle_outline_draw (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // command[0], x_origin[9:1], y_origin[18:10], signed_width[27:19],
   // signed_height[36:28], pen_color[44:37], zero fill[47:45]
   input  logic [rod_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // pixel_value[7:0]
   output logic [rod_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_we,
   input  logic [rod_pkg::CSR_IW-1:0]  csr_index,
   input  logic [rod_pkg::REG_W-1:0]   csr_wdata
);

   logic [rod_pkg::REG_W-1:0] cols_ff;
   logic [rod_pkg::REG_W-1:0] cols_in;
   logic [rod_pkg::REG_W-1:0] rows_ff;
   logic [rod_pkg::REG_W-1:0] rows_in;
   rod_pkg::dims_type         dims;
   rod_pkg::cmd_type          push_item;
   rod_pkg::cmd_type          head;
   logic                      push;
   logic                      pop;
   logic                      empty;
   logic                      full;
   logic                      clear_active;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            rod_pkg::CSR_COLUMNS: cols_in = csr_wdata;
            rod_pkg::CSR_ROWS:    rows_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= rod_pkg::REG_W'(128);
         rows_ff <= rod_pkg::REG_W'(128);
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // Sizes above the framebuffer maximum act as the maximum.
   assign dims.cols = (32'(cols_ff) > rod_pkg::MAX_COLUMNS)
                      ? rod_pkg::REG_W'(rod_pkg::MAX_COLUMNS) : cols_ff;
   assign dims.rows = (32'(rows_ff) > rod_pkg::MAX_ROWS)
                      ? rod_pkg::REG_W'(rod_pkg::MAX_ROWS) : rows_ff;

   rod_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .queue_full   (full),
      .clear_active (clear_active),
      .push         (push),
      .item         (push_item)
   );

   rod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   rod_back u_back (
      .clock        (clock),
      .reset        (reset),
      .dims         (dims),
      .head         (head),
      .empty        (empty),
      .pop          (pop),
      .clear_active (clear_active),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule
